[src/mhu_pkg.sv]
// Shared types and constants for the magnetometer heading unit.
// Depends on nothing; every other file of the block imports it.
package mhu_pkg;

    localparam int IN_W    = 48;
    localparam int OUT_W   = 128;
    localparam int RAW_W   = 16;
    localparam int GAUSS_W = 21;
    localparam int HEAD_W  = 17;

    // cordic datapath: |v| * 2^16 fits 33 bits, gain and sign add two
    localparam int XY_W  = 35;
    // angle accumulator, units of 1e-11 degree
    localparam int Z_W   = 45;
    localparam int ANG_W = 46;

    localparam int TAB_LEN = 24;

    localparam logic [63:0] ANG_UNIT  = 64'd100000000000;
    localparam logic [63:0] HALF_UNIT = 64'd50000000000;
    localparam logic [63:0] DEG90     = 64'd9000000000000;
    localparam logic [63:0] DEG180    = 64'd18000000000000;
    localparam logic [63:0] DEG360    = 64'd36000000000000;

    // atan(2^-i) in degrees, 1e-11 degree units
    localparam longint ATAN_TAB [TAB_LEN] = '{
        64'sd4500000000000, 64'sd2656505117708, 64'sd1403624346793, 64'sd712501634890,
        64'sd357633437500,  64'sd178991060825,  64'sd89517371021,   64'sd44761417086,
        64'sd22381050037,   64'sd11190567707,   64'sd5595289189,    64'sd2797645262,
        64'sd1398822714,    64'sd699411368,     64'sd349705685,     64'sd174852843,
        64'sd87426421,      64'sd43713211,      64'sd21856605,      64'sd10928303,
        64'sd5464151,       64'sd2732076,       64'sd1366038,       64'sd683019
    };

    // gauss scale: raw * 65536 / 3750 == raw * 32768 / 1875
    localparam int GAUSS_DIV_W   = 11;
    localparam int GAUSS_RECIP_W = 21;
    localparam logic [GAUSS_DIV_W-1:0]   GAUSS_DIV   = 11'd1875;
    localparam logic [GAUSS_RECIP_W-1:0] GAUSS_RECIP = 21'd1145324; // floor(2^31 / 1875)

    typedef struct packed {
        logic                   valid;
        logic                   xneg;
        logic                   yneg;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

endpackage

[src/mhu_cordic_cell.sv]
// One vectoring rotation cell of the heading chain.
// Depends on mhu_pkg (t_cordic, arctangent table).
module mhu_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  mhu_pkg::t_cordic i_d,
    output mhu_pkg::t_cordic o_d
);
    import mhu_pkg::*;

    localparam logic signed [Z_W-1:0] ANG_STEP = Z_W'(ATAN_TAB[STAGE]);

    logic signed [XY_W-1:0] w_x;
    logic signed [XY_W-1:0] w_y;
    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;
    t_cordic n_d;
    t_cordic r_d;

    assign w_x  = i_d.x;
    assign w_y  = i_d.y;
    assign w_xs = w_x >>> STAGE;
    assign w_ys = w_y >>> STAGE;

    always_comb begin
        n_d = i_d;
        if (w_y != '0) begin
            if (!w_y[XY_W-1]) begin
                n_d.x = w_x + w_ys;
                n_d.y = w_y - w_xs;
                n_d.z = i_d.z + ANG_STEP;
            end else begin
                n_d.x = w_x - w_ys;
                n_d.y = w_y + w_xs;
                n_d.z = i_d.z - ANG_STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[src/mhu_div_cell.sv]
// Three-stage divide by 1e11 for the heading: reciprocal estimate, then one correction step.
// Depends on mhu_pkg (ANG_UNIT).
module mhu_div_cell #(
    parameter int NW = 54,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    output logic          o_valid,
    output logic [QW-1:0] o_quo
);
    import mhu_pkg::*;

    // estimate from the bits above 2^36; it is exact or one low
    localparam int SH     = 36;
    localparam int NH_W   = NW - SH;
    localparam int K      = NH_W + 2;
    localparam int PROD_W = NH_W + K;
    localparam int REM_W  = 38;
    localparam int LO_SH  = 11;
    localparam int QD_W   = REM_W - LO_SH;
    localparam int QP_W   = QW + 26;
    // 1e11 == 5^11 * 2^11
    localparam logic [63:0]     DIV5   = ANG_UNIT >> LO_SH;
    localparam logic [K-1:0]    RECIP  = K'((64'd1 << (K + SH - LO_SH)) / DIV5);
    localparam logic [QP_W-1:0] DIV5_Q = QP_W'(DIV5);

    logic [NH_W-1:0]   w_nh;
    logic [QW-1:0]     w_q0;
    logic [REM_W-1:0]  w_rem;
    logic [QW-1:0]     w_q;

    logic              r1_valid;
    logic [PROD_W-1:0] r1_prod;
    logic [REM_W-1:0]  r1_lo;
    logic              r2_valid;
    logic [QW-1:0]     r2_q0;
    logic [QD_W-1:0]   r2_qd;
    logic [REM_W-1:0]  r2_lo;
    logic              r3_valid;
    logic [QW-1:0]     r3_quo;

    assign w_nh  = i_num[NW-1:SH];
    assign w_q0  = QW'(r1_prod >> K);
    // remainder is below 2e11, so the low bits are enough
    assign w_rem = r2_lo - {r2_qd, {LO_SH{1'b0}}};
    assign w_q   = r2_q0 + QW'(w_rem >= ANG_UNIT[REM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= w_nh * RECIP;
            r1_lo   <= i_num[REM_W-1:0];
            r2_q0   <= w_q0;
            r2_qd   <= QD_W'(w_q0 * DIV5_Q);
            r2_lo   <= r1_lo;
            r3_quo  <= w_q;
        end
    end

    assign o_valid = r3_valid;
    assign o_quo   = r3_quo;

endmodule

[src/mhu_gauss_div.sv]
// Three-stage scaler: raw reading to signed Q.16 gauss, truncated toward zero.
// Depends on mhu_pkg (reciprocal and divisor constants).
module mhu_gauss_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [mhu_pkg::RAW_W-1:0] i_raw,
    output logic signed [mhu_pkg::RAW_W-1:0] o_raw,
    output logic signed [mhu_pkg::GAUSS_W-1:0] o_gauss
);
    import mhu_pkg::*;

    localparam int A_W    = RAW_W + 1;
    localparam int PROD_W = A_W + GAUSS_RECIP_W;
    localparam int Q_W    = GAUSS_W - 1;
    localparam int QM_W   = Q_W + GAUSS_DIV_W;
    localparam int REM_W  = A_W + 15;

    logic [A_W-1:0]   w_ext;
    logic [A_W-1:0]   w_abs;
    logic [Q_W-1:0]   w_q0;
    logic [REM_W-1:0] w_rem;
    logic [Q_W-1:0]   w_q;

    logic [PROD_W-1:0]       r1_prod;
    logic [A_W-1:0]          r1_a;
    logic                    r1_neg;
    logic signed [RAW_W-1:0] r1_raw;
    logic [Q_W-1:0]          r2_q0;
    logic [QM_W-1:0]         r2_qm;
    logic [A_W-1:0]          r2_a;
    logic                    r2_neg;
    logic signed [RAW_W-1:0] r2_raw;
    logic signed [GAUSS_W-1:0] r3_gauss;
    logic signed [RAW_W-1:0] r3_raw;

    assign w_ext = {i_raw[RAW_W-1], i_raw};
    assign w_abs = i_raw[RAW_W-1] ? (~w_ext + 1'b1) : w_ext;
    assign w_q0  = r1_prod[16 +: Q_W];
    assign w_rem = {r2_a, 15'b0} - REM_W'(r2_qm);
    // estimate is exact or one low
    assign w_q   = r2_q0 + Q_W'(w_rem >= REM_W'(GAUSS_DIV));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod  <= w_abs * GAUSS_RECIP;
            r1_a     <= w_abs;
            r1_neg   <= i_raw[RAW_W-1];
            r1_raw   <= i_raw;
            r2_q0    <= w_q0;
            r2_qm    <= w_q0 * GAUSS_DIV;
            r2_a     <= r1_a;
            r2_neg   <= r1_neg;
            r2_raw   <= r1_raw;
            r3_gauss <= r2_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
            r3_raw   <= r2_raw;
        end
    end

    assign o_raw   = r3_raw;
    assign o_gauss = r3_gauss;

endmodule

[src/magnetometer_heading_unit.sv]
// Magnetometer heading unit top level: input skid, cordic chain, reciprocal divider, output.
// Depends on mhu_pkg, mhu_cordic_cell, mhu_div_cell, mhu_gauss_div.
//
// Takes one six-byte sample per clock and returns raw X/Y/Z, X/Y/Z in Q.16 gauss and the
// compass heading in 1/2^HEADING_FRAC_BITS degree. The pipeline holds, with
// N = min(ANGLE_STAGES, 24): a front register, N cordic cells, the fold register, three
// divider stages and the output register. Every stage retires one request per cycle, so
// a new sample enters every clock while the output is not stalled. A stalled output freezes
// the whole pipeline; one more request is held in the input skid register meanwhile.
module magnetometer_heading_unit #(
    parameter int HEADING_FRAC_BITS = 8,
    parameter int ANGLE_STAGES      = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  logic [mhu_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // x_raw, y_raw, z_raw, x_gauss, y_gauss, z_gauss, heading
    output logic [mhu_pkg::OUT_W-1:0]    o_m_axis_tdata
);
    import mhu_pkg::*;

    localparam int F       = HEADING_FRAC_BITS;
    localparam int N_CELLS = (ANGLE_STAGES < TAB_LEN) ? ANGLE_STAGES : TAB_LEN;
    localparam logic [63:0] LIMIT = 64'd360 << F;
    localparam logic [63:0] Q90   = 64'd90 << F;
    localparam logic [63:0] NMAX  = (DEG360 << F) + HALF_UNIT;
    localparam int QW    = $clog2(LIMIT + 64'd1);
    localparam int NW    = $clog2(NMAX + 64'd1);
    localparam int DLY   = N_CELLS + 2;
    localparam int MEAS_W = 3 * RAW_W + 3 * GAUSS_W;

    localparam logic [1:0] QUAD_NE = 2'b00;
    localparam logic [1:0] QUAD_NW = 2'b10;
    localparam logic [1:0] QUAD_SW = 2'b11;

    logic            w_adv;
    logic            w_in_acc;
    logic            w_pipe_valid;
    logic [IN_W-1:0] w_pipe_data;
    logic            r_skid_valid;
    logic [IN_W-1:0] r_skid_data;

    logic signed [RAW_W-1:0] w_xr, w_yr, w_zr;
    logic [RAW_W:0]          w_ax, w_ay;
    t_cordic                 n_front;
    t_cordic                 r_front;

    logic signed [RAW_W-1:0] r_raw_x, r_raw_y, r_raw_z;
    logic signed [RAW_W-1:0] w_gr_x, w_gr_y, w_gr_z;
    logic signed [GAUSS_W-1:0] w_g_x, w_g_y, w_g_z;
    logic [MEAS_W-1:0]       r_dly [DLY];

    t_cordic w_cor [N_CELLS+1];

    logic signed [Z_W-1:0] w_z;
    logic signed [Z_W-1:0] w_zc;
    logic [ANG_W-1:0]      w_zu;
    logic [ANG_W-1:0]      w_ang;
    logic                  r_fold_valid;
    logic [NW-1:0]         r_fold_n;

    logic          w_div_valid;
    logic [QW-1:0] w_div_quo;

    logic          r_final_valid;
    logic [QW-1:0] r_hq;

    // handshake and input skid
    assign w_adv           = !r_final_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_valid;
    assign w_in_acc        = i_s_axis_tvalid && !r_skid_valid;
    assign w_pipe_valid    = r_skid_valid || w_in_acc;
    assign w_pipe_data     = r_skid_valid ? r_skid_data : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            r_skid_valid <= !w_adv;
        end else begin
            r_skid_valid <= w_in_acc && !w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid && w_in_acc && !w_adv) begin
            r_skid_data <= i_s_axis_tdata;
        end
    end

    // front stage: assemble readings, first-quadrant magnitudes
    assign w_xr = $signed(w_pipe_data[15:0]);
    assign w_yr = $signed(w_pipe_data[31:16]);
    assign w_zr = $signed(w_pipe_data[47:32]);
    assign w_ax = w_xr[RAW_W-1] ? (~{w_xr[RAW_W-1], w_xr} + 1'b1) : {1'b0, w_xr};
    assign w_ay = w_yr[RAW_W-1] ? (~{w_yr[RAW_W-1], w_yr} + 1'b1) : {1'b0, w_yr};

    always_comb begin
        n_front.valid = w_pipe_valid;
        n_front.xneg  = w_xr[RAW_W-1];
        n_front.yneg  = w_yr[RAW_W-1];
        n_front.x     = XY_W'({w_ax, 16'b0});
        n_front.y     = XY_W'({w_ay, 16'b0});
        n_front.z     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_adv) begin
            r_front <= n_front;
        end
    end

    assign w_cor[0] = r_front;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_raw_x <= w_xr;
            r_raw_y <= w_yr;
            r_raw_z <= w_zr;
        end
    end

    // scaled readings, then delay to line up with the heading
    mhu_gauss_div u_gauss_x (
        .i_clk(i_clk), .i_en(w_adv), .i_raw(r_raw_x), .o_raw(w_gr_x), .o_gauss(w_g_x)
    );
    mhu_gauss_div u_gauss_y (
        .i_clk(i_clk), .i_en(w_adv), .i_raw(r_raw_y), .o_raw(w_gr_y), .o_gauss(w_g_y)
    );
    mhu_gauss_div u_gauss_z (
        .i_clk(i_clk), .i_en(w_adv), .i_raw(r_raw_z), .o_raw(w_gr_z), .o_gauss(w_g_z)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly[0] <= {w_g_z, w_g_y, w_g_x, w_gr_z, w_gr_y, w_gr_x};
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // vectoring chain
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cordic
        mhu_cordic_cell #(.STAGE(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_d     (w_cor[k]),
            .o_d     (w_cor[k+1])
        );
    end

    // clamp, quadrant fold, scale and add half unit
    assign w_z  = w_cor[N_CELLS].z;
    assign w_zc = w_z[Z_W-1] ? '0 :
                  ($unsigned(w_z) > Z_W'(DEG90)) ? $signed(Z_W'(DEG90)) : w_z;
    assign w_zu = ANG_W'(w_zc);

    always_comb begin
        case ({w_cor[N_CELLS].xneg, w_cor[N_CELLS].yneg})
            QUAD_NE: w_ang = w_zu;
            QUAD_NW: w_ang = ANG_W'(DEG180) - w_zu;
            QUAD_SW: w_ang = ANG_W'(DEG180) + w_zu;
            default: w_ang = ANG_W'(DEG360) - w_zu;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_valid <= 1'b0;
        end else if (w_adv) begin
            r_fold_valid <= w_cor[N_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fold_n <= (NW'(w_ang) << F) + NW'(HALF_UNIT);
        end
    end

    // divide by 1e11
    mhu_div_cell #(.NW(NW), .QW(QW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_fold_valid),
        .i_num   (r_fold_n),
        .o_valid (w_div_valid),
        .o_quo   (w_div_quo)
    );

    // full circle wraps to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_valid <= 1'b0;
        end else if (w_adv) begin
            r_final_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hq <= (w_div_quo == LIMIT[QW-1:0]) ? '0 : w_div_quo;
        end
    end

    assign o_m_axis_tvalid = r_final_valid;
    assign o_m_axis_tdata  = {HEAD_W'(r_hq), r_dly[DLY-1]};

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(!w_adv))
        else $error("skid loaded while pipeline advanced");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_hq < LIMIT[QW-1:0]))
        else $error("heading not below full circle");

    a_first_quadrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[15] && !o_m_axis_tdata[31])
        |-> (r_hq <= Q90[QW-1:0]))
        else $error("heading out of quadrant of its raw readings");

    a_div_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_valid |-> (w_div_quo <= LIMIT[QW-1:0]))
        else $error("divider quotient above full circle");

endmodule
